>>> sv/sclp_pkg.sv
// Shared types, character codes and keyword tables of the serial command line parser.
package sclp_pkg;

    localparam int KW_COUNT = 5;

    localparam logic [2:0] KW_REG     = 3'd0;
    localparam logic [2:0] KW_REGS    = 3'd1;
    localparam logic [2:0] KW_RESTART = 3'd2;
    localparam logic [2:0] KW_SAVE    = 3'd3;
    localparam logic [2:0] KW_MEM     = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUERY = 8'h3F;

    typedef enum logic [2:0] {
        CMD_UNKNOWN,
        CMD_GET_REG,
        CMD_SET_REG,
        CMD_GET_ALL,
        CMD_RESTART,
        CMD_SAVE,
        CMD_FREE_MEM,
        CMD_OVERFLOW
    } cmd_kind_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CHAR,
        OP_FINISH,
        OP_OVERFLOW
    } op_kind_t;

    typedef struct packed {
        logic       lead_cr;
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] index;
        logic signed [31:0] value;
    } result_t;

    typedef enum logic [1:0] {
        DEC_SKIP,
        DEC_POS,
        DEC_NEG,
        DEC_DONE
    } dec_phase_t;

    function automatic logic [2:0] kw_length(input logic [2:0] k);
        logic [2:0] len;
        case (k)
            KW_REG:     len = 3'd3;
            KW_REGS:    len = 3'd4;
            KW_RESTART: len = 3'd7;
            KW_SAVE:    len = 3'd4;
            KW_MEM:     len = 3'd3;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [63:0] kw_text(input logic [2:0] k);
        logic [63:0] t;
        case (k)
            KW_REG:     t = {"REG", 40'h0};
            KW_REGS:    t = {"REGS", 32'h0};
            KW_RESTART: t = {"RESTART", 8'h0};
            KW_SAVE:    t = {"SAVE", 32'h0};
            KW_MEM:     t = {"MEM", 40'h0};
            default:    t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic kw_char_match(input logic [2:0] k, input logic [4:0] p,
                                           input logic [7:0] c);
        logic [63:0] t;
        logic [7:0]  ch;
        t  = kw_text(k);
        ch = t[8 * (7 - int'(p[2:0])) +: 8];
        return (p < {2'b00, kw_length(k)}) && (ch == c);
    endfunction

endpackage

>>> sv/sclp_fifo.sv
// Small first-in first-out queue in flip-flops with show-ahead read.
module sclp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/sclp_front.sv
// Front end: counts line bytes, resolves CR LF and NUL, classifies each request into an op.
module sclp_front #(
    parameter int LINE_LIMIT = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       rx_byte,
    output logic             full,
    output logic             op_push,
    output sclp_pkg::op_t    op_wdata,
    input  logic             op_full
);

    localparam int CNT_W = $clog2(LINE_LIMIT);
    localparam int INC_W = CNT_W + 1;

    logic [CNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic             cr_pending_reg, cr_pending_next;
    logic [INC_W-1:0] cnt_inc;
    logic             accept;
    sclp_pkg::op_t    op;

    assign full    = op_full;
    assign accept  = push && !op_full;
    assign cnt_inc = {1'b0, line_cnt_reg} + INC_W'(1);

    always_comb
    begin
        op.lead_cr      = 1'b0;
        op.kind         = sclp_pkg::OP_NONE;
        op.data         = rx_byte;
        line_cnt_next   = line_cnt_reg;
        cr_pending_next = cr_pending_reg;
        if (accept)
        begin
            if (cnt_inc >= INC_W'(LINE_LIMIT))
            begin
                op.kind         = sclp_pkg::OP_OVERFLOW;
                line_cnt_next   = '0;
                cr_pending_next = 1'b0;
            end
            else if (cr_pending_reg && rx_byte == sclp_pkg::CH_LF && cnt_inc > INC_W'(2))
            begin
                op.kind         = sclp_pkg::OP_FINISH;
                line_cnt_next   = '0;
                cr_pending_next = 1'b0;
            end
            else
            begin
                // replay a held CR as text ahead of this byte
                op.lead_cr      = cr_pending_reg;
                line_cnt_next   = cnt_inc[CNT_W-1:0];
                cr_pending_next = 1'b0;
                if (rx_byte == sclp_pkg::CH_NUL)
                begin
                    op.kind       = sclp_pkg::OP_FINISH;
                    line_cnt_next = '0;
                end
                else if (rx_byte == sclp_pkg::CH_CR)
                begin
                    cr_pending_next = 1'b1;
                end
                else
                begin
                    op.kind = sclp_pkg::OP_CHAR;
                end
            end
        end
    end

    assign op_push  = accept && (op.lead_cr || op.kind != sclp_pkg::OP_NONE);
    assign op_wdata = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg   <= '0;
            cr_pending_reg <= 1'b0;
        end
        else
        begin
            line_cnt_reg   <= line_cnt_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, line_cnt_reg} < INC_W'(LINE_LIMIT))
        else $error("line count reached the limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cr_pending_reg |-> line_cnt_reg != '0)
        else $error("pending CR in an empty line");

endmodule

>>> sv/sclp_back.sv
// Back end: tokenizes ops, matches keywords, reads decimals and issues command results.
module sclp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sclp_pkg::op_t     op_rdata,
    input  logic              op_empty,
    output logic              op_pop,
    output logic              res_push,
    output sclp_pkg::result_t res_wdata,
    input  logic              res_full
);

    typedef struct packed {
        sclp_pkg::dec_phase_t phase;
        logic [31:0]          acc;
    } dec_t;

    function automatic dec_t dec_step(input logic [31:0] acc, input sclp_pkg::dec_phase_t ph,
                                      input logic [7:0] c);
        logic        digit;
        logic [31:0] d;
        logic [31:0] x10;
        dec_t        r;
        digit   = (c >= sclp_pkg::CH_ZERO) && (c <= sclp_pkg::CH_NINE);
        d       = {28'd0, c[3:0]};
        x10     = (acc << 3) + (acc << 1);
        r.phase = ph;
        r.acc   = acc;
        case (ph)
            sclp_pkg::DEC_SKIP:
            begin
                if (c inside {sclp_pkg::CH_TAB, sclp_pkg::CH_LF, sclp_pkg::CH_VT,
                              sclp_pkg::CH_FF, sclp_pkg::CH_CR})
                begin
                    r.phase = sclp_pkg::DEC_SKIP;
                end
                else if (c == sclp_pkg::CH_PLUS)
                begin
                    r.phase = sclp_pkg::DEC_POS;
                end
                else if (c == sclp_pkg::CH_MINUS)
                begin
                    r.phase = sclp_pkg::DEC_NEG;
                end
                else if (digit)
                begin
                    r.acc   = d;
                    r.phase = sclp_pkg::DEC_POS;
                end
                else
                begin
                    r.phase = sclp_pkg::DEC_DONE;
                end
            end
            sclp_pkg::DEC_POS:
            begin
                if (digit)
                begin
                    r.acc = x10 + d;
                end
                else
                begin
                    r.phase = sclp_pkg::DEC_DONE;
                end
            end
            sclp_pkg::DEC_NEG:
            begin
                if (digit)
                begin
                    r.acc = x10 - d;
                end
                else
                begin
                    r.phase = sclp_pkg::DEC_DONE;
                end
            end
            default:
            begin
                r.phase = ph;
            end
        endcase
        return r;
    endfunction

    logic [2:0]                 tok_num_reg, tok_num_next;
    logic                       in_tok_reg, in_tok_next;
    logic [4:0]                 cit_reg, cit_next;
    logic [4:0]                 kw_reg, kw_next;
    logic [31:0]                idx_acc_reg, idx_acc_next;
    sclp_pkg::dec_phase_t       idx_ph_reg, idx_ph_next;
    logic [31:0]                val_acc_reg, val_acc_next;
    sclp_pkg::dec_phase_t       val_ph_reg, val_ph_next;
    logic [2:0]                 qflags_reg, qflags_next;
    logic                       cr_done_reg, cr_done_next;

    logic                       step_cr;
    logic                       is_end;
    logic                       advance;
    logic [7:0]                 c;
    logic [4:0]                 len_keep;
    logic [4:0]                 kw_close;
    logic [4:0]                 p;
    logic [2:0]                 tn;
    dec_t                       idx_dec;
    dec_t                       val_dec;
    sclp_pkg::cmd_kind_t        fin_kind;
    logic [31:0]                fin_idx;
    logic [31:0]                fin_val;

    assign step_cr = op_rdata.lead_cr && !cr_done_reg;
    assign is_end  = !step_cr && (op_rdata.kind == sclp_pkg::OP_FINISH ||
                                  op_rdata.kind == sclp_pkg::OP_OVERFLOW);
    assign advance = !op_empty && (!is_end || !res_full);
    assign op_pop  = advance && (!step_cr || op_rdata.kind == sclp_pkg::OP_NONE);
    assign c       = step_cr ? sclp_pkg::CH_CR : op_rdata.data;

    always_comb
    begin
        for (int k = 0; k < sclp_pkg::KW_COUNT; k++)
        begin
            len_keep[k] = ({2'b00, sclp_pkg::kw_length(3'(k))} == cit_reg);
        end
        kw_close = (in_tok_reg && tok_num_reg == 3'd1) ? (kw_reg & len_keep) : kw_reg;
        p        = in_tok_reg ? cit_reg : 5'd0;
        tn       = in_tok_reg ? tok_num_reg :
                   ((tok_num_reg == 3'd7) ? 3'd7 : tok_num_reg + 3'd1);
        idx_dec  = dec_step(idx_acc_reg, idx_ph_reg, c);
        val_dec  = dec_step(val_acc_reg, val_ph_reg, c);
    end

    // command decode at end of line
    always_comb
    begin
        fin_kind = sclp_pkg::CMD_UNKNOWN;
        fin_idx  = '0;
        fin_val  = '0;
        if (tok_num_reg == 3'd0)
        begin
            fin_kind = sclp_pkg::CMD_UNKNOWN;
        end
        else if (kw_close[sclp_pkg::KW_REG])
        begin
            if (tok_num_reg >= 3'd3)
            begin
                fin_idx = idx_acc_reg;
                if (qflags_reg[1] && !qflags_reg[2])
                begin
                    fin_kind = sclp_pkg::CMD_GET_REG;
                end
                else
                begin
                    fin_kind = sclp_pkg::CMD_SET_REG;
                    fin_val  = val_acc_reg;
                end
            end
        end
        else if (kw_close[sclp_pkg::KW_REGS])
        begin
            if (tok_num_reg >= 3'd2 && qflags_reg[0])
            begin
                fin_kind = sclp_pkg::CMD_GET_ALL;
            end
        end
        else if (kw_close[sclp_pkg::KW_RESTART])
        begin
            fin_kind = sclp_pkg::CMD_RESTART;
        end
        else if (kw_close[sclp_pkg::KW_SAVE])
        begin
            fin_kind = sclp_pkg::CMD_SAVE;
        end
        else if (kw_close[sclp_pkg::KW_MEM])
        begin
            if (tok_num_reg >= 3'd2 && qflags_reg[0])
            begin
                fin_kind = sclp_pkg::CMD_FREE_MEM;
            end
        end
    end

    always_comb
    begin
        res_push = advance && is_end;
        if (op_rdata.kind == sclp_pkg::OP_OVERFLOW)
        begin
            res_wdata.kind  = sclp_pkg::CMD_OVERFLOW;
            res_wdata.index = '0;
            res_wdata.value = '0;
        end
        else
        begin
            res_wdata.kind  = fin_kind;
            res_wdata.index = fin_idx;
            res_wdata.value = fin_val;
        end
    end

    always_comb
    begin
        tok_num_next = tok_num_reg;
        in_tok_next  = in_tok_reg;
        cit_next     = cit_reg;
        kw_next      = kw_reg;
        idx_acc_next = idx_acc_reg;
        idx_ph_next  = idx_ph_reg;
        val_acc_next = val_acc_reg;
        val_ph_next  = val_ph_reg;
        qflags_next  = qflags_reg;
        cr_done_next = cr_done_reg;
        if (advance)
        begin
            cr_done_next = !op_pop;
            if (is_end)
            begin
                tok_num_next = '0;
                in_tok_next  = 1'b0;
                cit_next     = '0;
                kw_next      = '1;
                idx_acc_next = '0;
                idx_ph_next  = sclp_pkg::DEC_SKIP;
                val_acc_next = '0;
                val_ph_next  = sclp_pkg::DEC_SKIP;
                qflags_next  = '0;
            end
            else if (c == sclp_pkg::CH_SPACE || c == sclp_pkg::CH_COLON)
            begin
                kw_next     = kw_close;
                in_tok_next = 1'b0;
            end
            else
            begin
                in_tok_next  = 1'b1;
                tok_num_next = tn;
                if (tn == 3'd1)
                begin
                    for (int k = 0; k < sclp_pkg::KW_COUNT; k++)
                    begin
                        if (!sclp_pkg::kw_char_match(3'(k), p, c))
                        begin
                            kw_next[k] = 1'b0;
                        end
                    end
                end
                else if (tn == 3'd2)
                begin
                    idx_acc_next = idx_dec.acc;
                    idx_ph_next  = idx_dec.phase;
                    if (p == 5'd0 && c == sclp_pkg::CH_QUERY)
                    begin
                        qflags_next[0] = 1'b1;
                    end
                end
                else if (tn == 3'd3)
                begin
                    val_acc_next = val_dec.acc;
                    val_ph_next  = val_dec.phase;
                    if (p == 5'd0 && c == sclp_pkg::CH_QUERY)
                    begin
                        qflags_next[1] = 1'b1;
                    end
                    if (p != 5'd0)
                    begin
                        qflags_next[2] = 1'b1;
                    end
                end
                cit_next = (p == 5'd31) ? 5'd31 : p + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_num_reg <= '0;
            in_tok_reg  <= 1'b0;
            cit_reg     <= '0;
            kw_reg      <= '1;
            idx_acc_reg <= '0;
            idx_ph_reg  <= sclp_pkg::DEC_SKIP;
            val_acc_reg <= '0;
            val_ph_reg  <= sclp_pkg::DEC_SKIP;
            qflags_reg  <= '0;
            cr_done_reg <= 1'b0;
        end
        else
        begin
            tok_num_reg <= tok_num_next;
            in_tok_reg  <= in_tok_next;
            cit_reg     <= cit_next;
            kw_reg      <= kw_next;
            idx_acc_reg <= idx_acc_next;
            idx_ph_reg  <= idx_ph_next;
            val_acc_reg <= val_acc_next;
            val_ph_reg  <= val_ph_next;
            qflags_reg  <= qflags_next;
            cr_done_reg <= cr_done_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end) |=> (tok_num_reg == 3'd0 && !in_tok_reg && kw_reg == 5'h1F &&
                                 qflags_reg == 3'd0))
        else $error("line state not cleared after end of line");

    assert property (@(posedge clk) disable iff (!rst_n)
        cr_done_reg |-> (!op_empty && op_rdata.lead_cr && op_rdata.kind != sclp_pkg::OP_NONE))
        else $error("replayed CR without a waiting op");

endmodule

>>> sv/serial_command_line_parser_top.sv
// Top level of the serial command line parser: front end, op queue, back end, result queue.
//
// Bytes enter through push/full at up to one per cycle while full is low, and each ended
// line leaves one command result through empty/pop. The byte ending a line goes through the
// op queue and the back end into the result queue, behind any held CR that the back end is
// still replaying as text ahead of it. That replay costs the back end an extra step for a
// byte that follows a CR, but the CR itself costs it none, so the back end keeps up with one
// byte per cycle unless the result queue is full. The op queue (OP_DEPTH entries) absorbs the
// replay and any stall on the result side; full rises only when it fills, which happens only
// while results wait unread. A line reaching LINE_LIMIT bytes yields an overflow result.
module serial_command_line_parser_top #(
    parameter int LINE_LIMIT = 20,
    parameter int OP_DEPTH   = 4,
    parameter int RES_DEPTH  = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         command_kind,
    output logic signed [31:0] register_index,
    output logic signed [31:0] register_value
);

    localparam int OP_W  = $bits(sclp_pkg::op_t);
    localparam int RES_W = $bits(sclp_pkg::result_t);

    logic              op_push;
    logic              op_full;
    logic              op_pop;
    logic              op_empty;
    sclp_pkg::op_t     op_wdata;
    sclp_pkg::op_t     op_head;
    logic              res_push;
    logic              res_full;
    sclp_pkg::result_t res_wdata;
    sclp_pkg::result_t res_head;

    sclp_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .op_push  (op_push),
        .op_wdata (op_wdata),
        .op_full  (op_full)
    );

    sclp_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_DEPTH)
    ) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wdata),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (op_head),
        .empty (op_empty)
    );

    sclp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_rdata  (op_head),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res_wdata (res_wdata),
        .res_full  (res_full)
    );

    sclp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign command_kind   = res_head.kind;
    assign register_index = res_head.index;
    assign register_value = res_head.value;

endmodule
